[design/wbb_pkg.sv]
// Shared types, widths and register indexes for the wraparound box blur.
// No dependencies; used by the top level, wbb_mean and wbb_chk.
package wbb_pkg;

	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int PIX_W          = CH_W * NUM_CH;
	localparam int RAD_W          = 2;
	localparam int DIM_W          = 9;
	localparam int CFG_DATA_W     = DIM_W;
	localparam int REG_IDX_W      = 2;
	localparam int MIN_DIM        = 8;
	localparam int MAX_RADIUS     = 3;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int RESET_RADIUS   = 1;
	localparam int RESET_DIM      = 256;
	localparam int SPAN_W         = RAD_W + 1;

	// widest window sum: (2*MAX_RADIUS+1)^2 full-scale pixels
	localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)
		* ((1 << CH_W) - 1) + 1);

	// mean = (sum * rcp) >> RCP_SHIFT, exact floor for every window sum
	localparam int RCP_W     = 17;
	localparam int RCP_SHIFT = 20;
	localparam int PROD_W    = SUM_W + RCP_W;

	typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;   // [0] red, [1] green, [2] blue
	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum3_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	// ceil(2^RCP_SHIFT / (2r+1)^2); radius zero passes the sum through unscaled
	function automatic logic [RCP_W-1:0] recip_f(input logic [RAD_W-1:0] r);
		logic [RCP_W-1:0] m;
		case (r)
			2'd1:    m = 17'd116509;
			2'd2:    m = 17'd41944;
			2'd3:    m = 17'd21400;
			default: m = 17'd1;
		endcase
		return m;
	endfunction

endpackage

[design/wraparound_box_blur.sv]
// Wraparound box blur top level. Load request: written to the frame store at acceptance, one a cycle
// while idle and no register write is settling. Emit request: the window is read one pixel per cycle;
// the next request is taken once the result enters the output register, which waits while an earlier
// result is held and not yet taken. The first emit after a register write runs the divider for the
// row/column split if in frame. Input stalls after each register write. Reset: radius 1, 256 x 256
// frame, load/emit positions zero; store not cleared. Uses wbb_pkg, wbb_store, wbb_divu, wbb_mean.
module wraparound_box_blur #(
	parameter int MAX_WIDTH  = wbb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wbb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wbb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [wbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [wbb_pkg::PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                           s_axis_tuser,  // cmd
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [wbb_pkg::PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
	output logic                           m_axis_tlast   // last_pixel
);

	import wbb_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int EWW   = (WW > DIM_W) ? WW : DIM_W;
	localparam int EHW   = (HW > DIM_W) ? HW : DIM_W;
	// pixel count of the frame size held at reset
	localparam int RST_COUNT = ((RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM)
		* ((RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_BASE  = 8'b0000_0100,
		ST_ROW   = 8'b0000_1000,
		ST_READ  = 8'b0001_0000,
		ST_DRAIN = 8'b0010_0000,
		ST_MUL   = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [RAD_W-1:0] radius_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             settle_q;
	logic             cfg_wr;
	logic [EWW-1:0]   fw_x;
	logic [EHW-1:0]   fh_x;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;
	logic [RAD_W-1:0] r_eff;
	logic [SPAN_W-1:0] span_m1;
	logic [WW+HW-1:0] area;
	logic [CW-1:0]    count_q;

	// positions
	logic [AW-1:0] load_p_q;
	logic [AW-1:0] emit_p_q;
	logic [AW-1:0] lp;
	logic [CW-1:0] lp_inc;
	logic [AW-1:0] ep;
	logic [CW-1:0] ep_inc;
	logic          in_range;
	logic          acc_in;
	logic          take_fast;
	logic          div_start;
	logic          coord_load;
	logic          xy_ok_q;
	logic          last_q;

	// coordinates
	logic [XW-1:0] cx_q, nx_q, src_x, nxt_x;
	logic [YW-1:0] cy_q, ny_q, src_y, nxt_y;
	logic [XW:0]   sx_inc;
	logic [YW:0]   sy_inc;

	// window walk
	logic [HW:0]       ys, yy0;
	logic [WW:0]       xs, xx0;
	logic [YW-1:0]     yy_q;
	logic [XW-1:0]     xx_q, xx0_q;
	logic [YW:0]       yy_inc;
	logic [XW:0]       xx_inc;
	logic              yy_wrap, xx_wrap;
	logic [YW+WW-1:0]  rowp;
	logic [AW-1:0]     rb_q;
	logic [AW:0]       rb_plus;
	logic [AW:0]       raddr_w;
	logic [SPAN_W-1:0] i_q, j_q;
	logic              rd_v_s1;
	pix_t              rd_data;
	sum3_t             sum_q;
	pix_t              mean;

	// divider
	logic          div_done;
	logic [AW-1:0] div_quot;
	logic [WW-1:0] div_rem;

	// output register
	logic  m_valid_q;
	pix_t  m_data_q;
	logic  m_last_q;
	logic  out_free;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		fw_x = EWW'(width_q);
		fh_x = EHW'(height_q);
		if (fw_x < EWW'(MIN_DIM))
			w_eff = WW'(MIN_DIM);
		else if (fw_x > EWW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(fw_x);
		if (fh_x < EHW'(MIN_DIM))
			h_eff = HW'(MIN_DIM);
		else if (fh_x > EHW'(MAX_HEIGHT))
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(fh_x);
		r_eff   = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
		span_m1 = {r_eff, 1'b0};
	end

	assign area = {HW'(0), w_eff} * {WW'(0), h_eff};

	// handshake and raster positions
	assign s_axis_tready = (state_q == ST_IDLE) && !settle_q;
	assign acc_in        = s_axis_tvalid & s_axis_tready;

	assign lp       = (CW'(load_p_q) < count_q) ? load_p_q : '0;
	assign lp_inc   = CW'(lp) + 1'b1;
	assign in_range = CW'(emit_p_q) < count_q;
	assign ep       = in_range ? emit_p_q : '0;
	assign ep_inc   = CW'(ep) + 1'b1;

	assign take_fast  = acc_in && s_axis_tuser && (xy_ok_q || !in_range);
	assign div_start  = acc_in && s_axis_tuser && !xy_ok_q && in_range;
	assign coord_load = take_fast || ((state_q == ST_DIV) && div_done);

	// coordinates of the pixel being emitted and of the one after it
	always_comb begin
		if (state_q == ST_DIV) begin
			src_x = div_rem[XW-1:0];
			src_y = div_quot[YW-1:0];
		end else if (in_range) begin
			src_x = nx_q;
			src_y = ny_q;
		end else begin
			src_x = '0;
			src_y = '0;
		end
		sx_inc = {1'b0, src_x} + 1'b1;
		sy_inc = {1'b0, src_y} + 1'b1;
		if (sx_inc == (XW+1)'(w_eff)) begin
			nxt_x = '0;
			nxt_y = (sy_inc == (YW+1)'(h_eff)) ? '0 : sy_inc[YW-1:0];
		end else begin
			nxt_x = sx_inc[XW-1:0];
			nxt_y = src_y;
		end
	end

	// window origin with toroidal wrap
	always_comb begin
		ys  = (HW+1)'(cy_q) + (HW+1)'(h_eff) - (HW+1)'(r_eff);
		yy0 = (ys >= (HW+1)'(h_eff)) ? ys - (HW+1)'(h_eff) : ys;
		xs  = (WW+1)'(cx_q) + (WW+1)'(w_eff) - (WW+1)'(r_eff);
		xx0 = (xs >= (WW+1)'(w_eff)) ? xs - (WW+1)'(w_eff) : xs;
	end

	assign rowp    = {WW'(0), yy_q} * {YW'(0), w_eff};
	assign yy_inc  = {1'b0, yy_q} + 1'b1;
	assign yy_wrap = yy_inc == (YW+1)'(h_eff);
	assign xx_inc  = {1'b0, xx_q} + 1'b1;
	assign xx_wrap = xx_inc == (XW+1)'(w_eff);
	assign rb_plus = (AW+1)'(rb_q) + (AW+1)'(w_eff);
	assign raddr_w = (AW+1)'(rb_q) + (AW+1)'(xx_q);

	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_fast)
					state_d = ST_BASE;
				else if (div_start)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_BASE;
			end
			ST_BASE:  state_d = ST_ROW;
			ST_ROW:   state_d = ST_READ;
			ST_READ: begin
				if (i_q == span_m1 && j_q == span_m1)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radius_q <= RAD_W'(RESET_RADIUS);
			width_q  <= DIM_W'(RESET_DIM);
			height_q <= DIM_W'(RESET_DIM);
			settle_q <= 1'b0;
			count_q  <= CW'(RST_COUNT);
			load_p_q <= '0;
			emit_p_q <= '0;
			xy_ok_q  <= 1'b1;
			last_q   <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			nx_q     <= '0;
			ny_q     <= '0;
			yy_q     <= '0;
			xx_q     <= '0;
			xx0_q    <= '0;
			rb_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			rd_v_s1  <= 1'b0;
			sum_q    <= '0;
			m_valid_q <= 1'b0;
			m_last_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			settle_q <= cfg_wr;
			count_q  <= area[CW-1:0];
			rd_v_s1  <= (state_q == ST_READ);

			if (cfg_wr) begin
				xy_ok_q <= 1'b0;
				case (cfg_index)
					REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
					REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end

			if (acc_in && !s_axis_tuser)
				load_p_q <= (lp_inc < count_q) ? lp_inc[AW-1:0] : '0;

			if (acc_in && s_axis_tuser) begin
				emit_p_q <= (ep_inc < count_q) ? ep_inc[AW-1:0] : '0;
				last_q   <= (CW'(ep) == count_q - 1'b1);
			end

			if (coord_load) begin
				cx_q    <= src_x;
				cy_q    <= src_y;
				nx_q    <= nxt_x;
				ny_q    <= nxt_y;
				xy_ok_q <= 1'b1;
			end

			if (state_q == ST_BASE) begin
				yy_q  <= yy0[YW-1:0];
				xx0_q <= xx0[XW-1:0];
			end

			if (state_q == ST_ROW) begin
				rb_q  <= rowp[AW-1:0];
				xx_q  <= xx0_q;
				i_q   <= '0;
				j_q   <= '0;
				sum_q <= '0;
			end else if (rd_v_s1) begin
				for (int c = 0; c < NUM_CH; c++)
					sum_q[c] <= sum_q[c] + SUM_W'(rd_data[c]);
			end

			if (state_q == ST_READ) begin
				if (i_q == span_m1) begin
					i_q  <= '0;
					j_q  <= j_q + 1'b1;
					xx_q <= xx0_q;
					yy_q <= yy_wrap ? '0 : yy_inc[YW-1:0];
					rb_q <= yy_wrap ? '0 : rb_plus[AW-1:0];
				end else begin
					i_q  <= i_q + 1'b1;
					xx_q <= xx_wrap ? '0 : xx_inc[XW-1:0];
				end
			end

			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
				m_data_q  <= mean;
				m_last_q  <= last_q;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	wbb_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (PIX_W)
	) u_store (
		.clk   (clk),
		.we    (acc_in && !s_axis_tuser),
		.waddr (lp),
		.wdata (s_axis_tdata),
		.re    (state_q == ST_READ),
		.raddr (raddr_w[AW-1:0]),
		.rdata (rd_data)
	);

	wbb_divu #(
		.NW (AW),
		.DW (WW)
	) u_divu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (emit_p_q),
		.divisor  (w_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	wbb_mean u_mean (
		.clk    (clk),
		.en     (state_q == ST_MUL),
		.radius (r_eff),
		.sums   (sum_q),
		.mean   (mean)
	);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

[design/wbb_store.sv]
// Frame store: single write port, single registered read port.
// Depends on nothing; sized by the top level.
module wbb_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[design/wbb_divu.sv]
// Restoring divider, one quotient bit a cycle; splits a raster index into row and column.
// Depends on nothing.
module wbb_divu #(
	parameter int NW = 16,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [NW-1:0]   quot_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic [DW:0]     rem_sub;
	logic            ge;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
				num_q  <= dividend;
				quot_q <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q  <= {num_q[NW-2:0], 1'b0};
				rem_q  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
				quot_q <= {quot_q[NW-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

[design/wbb_mean.sv]
// Window mean: scales the three channel sums by a reciprocal, one registered product stage.
// Depends on wbb_pkg (recip_f, sum and pixel types).
module wbb_mean (
	input  logic                      clk,
	input  logic                      en,
	input  logic [wbb_pkg::RAD_W-1:0] radius,
	input  wbb_pkg::sum3_t            sums,
	output wbb_pkg::pix_t             mean
);

	import wbb_pkg::*;

	logic [NUM_CH-1:0][PROD_W-1:0] prod_s1;
	logic                          bypass_s1;
	logic [RCP_W-1:0]              rcp;

	assign rcp = recip_f(radius);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_CH; c++)
				prod_s1[c] <= {RCP_W'(0), sums[c]} * {SUM_W'(0), rcp};
			bypass_s1 <= (radius == '0);
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++)
			mean[c] = bypass_s1 ? prod_s1[c][CH_W-1:0]
				: prod_s1[c][RCP_SHIFT+CH_W-1:RCP_SHIFT];
	end

endmodule

[design/wbb_chk.sv]
// Port-level checks for the wraparound box blur, bound to the top level.
// Depends on wbb_pkg for port widths.
module wbb_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [wbb_pkg::REG_IDX_W-1:0]  cfg_index,
	input logic [wbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [wbb_pkg::PIX_W-1:0]      s_axis_tdata,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [wbb_pkg::PIX_W-1:0]      m_axis_tdata,
	input logic                           m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// register writes settle before the next request
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_axis_tready)
		else $error("request taken straight after register write");

	// an emit request occupies the block
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("request taken while window walk starts");

	// a load request yields no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
			|=> !m_axis_tvalid)
		else $error("result appeared after load request");

endmodule

bind wraparound_box_blur wbb_chk u_wbb_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
